### rtl/gpps_pkg.sv
package gpps_pkg;

    localparam int PRICE_FIELD_W   = 48;
    localparam int DEF_PRICE_WIDTH = 48;
    localparam int DEF_EXP_DEPTH   = 256;
    localparam int EXP_W           = 12;
    localparam int MANT_W          = 35;
    localparam int ENTRY_W         = 34;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [PRICE_FIELD_W-1:0] START_PRICE_RESET = 48'd6553600;
    localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
    localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
    localparam logic [63:0]        ONE_Q32   = 64'h1_0000_0000;

    localparam logic [1:0] DIV_NONE = 2'd0;
    localparam logic [1:0] DIV_CASH = 2'd1;
    localparam logic [1:0] DIV_PROP = 2'd2;

    typedef struct packed {
        logic signed [15:0]       normal_sample;
        logic signed [19:0]       step_drift;
        logic [19:0]              step_vol;
        logic                     path_start;
        logic [1:0]               dividend_kind;
        logic [PRICE_FIELD_W-1:0] dividend_amount;
    } gpps_in_t;

    typedef struct packed {
        logic [PRICE_FIELD_W-1:0] price;
        logic                     saturated;
        logic                     floored;
    } gpps_out_t;

    typedef struct packed {
        logic                     path_start;
        logic [1:0]               dividend_kind;
        logic [PRICE_FIELD_W-1:0] dividend_amount;
    } gpps_side_t;

    typedef struct packed {
        logic signed [EXP_W-1:0] e;
        logic [MANT_W-1:0]       mant;
        gpps_side_t              side;
    } gpps_item_t;

    // 2^(j/depth) in Q32, truncating Taylor series of exp
    function automatic logic [ENTRY_W-1:0] exp_entry(input int unsigned j,
                                                     input int unsigned idxw);
        logic [63:0]  a;
        logic [127:0] prod;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic         done;
        a    = (64'(j) * 64'(LN2_Q32)) >> idxw;
        term = ONE_Q32;
        sum  = ONE_Q32;
        done = 1'b0;
        for (int k = 1; k < 40; k++)
        begin
            if (!done)
            begin
                prod = 128'(term) * 128'(a);
                term = 64'(prod >> 32) / 64'(k);
                if (term == 64'd0)
                    done = 1'b1;
                else
                    sum = sum + term;
            end
        end
        return ENTRY_W'(sum);
    endfunction

endpackage

### rtl/gbm_price_path_step_unit.sv
// Geometric Brownian motion path step. Each input transfer carries one normal
// draw and gives one price node: price = price * exp(drift + vol * sample),
// then an optional cash or proportional dividend; path_start reloads the
// price from start_price. The exp factor comes from a five-stage pipeline
// (table lookup plus quadratic correction) that does not depend on the price
// and feeds a two-entry queue. The running-price loop works on one item at a
// time, popping the next only from idle: queue pop, two partial products of
// the price multiply, shift/clamp, dividend and output register; the dividend
// step waits on a stalled output. EXP_TABLE_DEPTH must be a power of two.
// start_price is written through the cfg channel, which is always ready.
module gbm_price_path_step_unit
    import gpps_pkg::*;
#(
    parameter int PRICE_WIDTH     = DEF_PRICE_WIDTH,
    parameter int EXP_TABLE_DEPTH = DEF_EXP_DEPTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  gpps_in_t                 in_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output gpps_out_t                out_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [PRICE_FIELD_W-1:0] cfg_data
);

    logic [PRICE_FIELD_W-1:0] start_price_reg;
    logic                     push;
    logic                     q_full;
    logic                     q_valid;
    logic                     pop;
    gpps_item_t               push_data;
    gpps_item_t               q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_price_reg <= START_PRICE_RESET;
        else if (cfg_valid && cfg_ready)
            start_price_reg <= cfg_data;
    end

    gpps_front #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .push      (push),
        .q_full    (q_full),
        .push_data (push_data)
    );

    gpps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    gpps_back #(
        .PRICE_WIDTH (PRICE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_price (start_price_reg),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

### rtl/gpps_front.sv
module gpps_front
    import gpps_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = DEF_EXP_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  gpps_in_t   in_data,
    output logic       push,
    input  logic       q_full,
    output gpps_item_t push_data
);

    localparam int IDXW = $clog2(EXP_TABLE_DEPTH);
    localparam int TW   = 32 - IDXW;
    localparam int XW   = 26;

    logic [ENTRY_W-1:0] exp_tbl [EXP_TABLE_DEPTH];

    for (genvar j = 0; j < EXP_TABLE_DEPTH; j++)
    begin : g_tbl
        localparam logic [ENTRY_W-1:0] ENTRY = exp_entry(j, IDXW);
        assign exp_tbl[j] = ENTRY;
    end

    logic [5:1] v_reg;
    logic       advance;

    logic signed [36:0]      sv_reg;
    logic signed [19:0]      drift_reg;
    logic signed [57:0]      ym_reg;
    logic [63:0]             rp_reg;
    logic [TW-1:0]           t_reg;
    logic [2*TW-1:0]         tt_reg;
    logic [IDXW-1:0]         idx3_reg, idx4_reg;
    logic signed [EXP_W-1:0] e3_reg, e4_reg, e5_reg;
    logic [MANT_W-1:0]       mant_reg;
    gpps_side_t              side_reg [1:5];

    logic signed [36:0]      sv_next;
    logic signed [36:0]      sv_rnd;
    logic signed [XW-1:0]    x;
    logic signed [57:0]      ym_next;
    logic signed [43:0]      y;
    logic [31:0]             f;
    logic [31:0]             rem;
    logic [63:0]             rp_next;
    logic [TW-1:0]           t_next;
    logic [2*TW-1:0]         tt_next;
    logic [33:0]             corr;
    logic [65:0]             mprod;
    logic [MANT_W-1:0]       mant_next;

    assign advance  = !(v_reg[5] && q_full);
    assign in_stall = !advance;
    assign push     = v_reg[5] && !q_full;

    always_comb
    begin
        sv_next   = in_data.normal_sample * $signed({17'd0, in_data.step_vol});
        sv_rnd    = sv_reg + 37'sd2048;
        x         = XW'(sv_rnd >>> 12) + XW'(drift_reg);
        ym_next   = x * LOG2E_Q30;
        y         = 44'(ym_reg >>> 14);
        f         = y[31:0];
        rem       = {f[31-IDXW:0], {IDXW{1'b0}}};
        rp_next   = 64'(rem) * 64'(LN2_Q32);
        t_next    = rp_reg[63 -: TW];
        tt_next   = (2*TW)'(t_next) * (2*TW)'(t_next);
        corr      = 34'(ONE_Q32) + 34'(t_reg) + 34'(tt_reg >> 33);
        mprod     = 66'(exp_tbl[idx4_reg]) * 66'(corr[33:2]);
        mant_next = mprod[30 +: MANT_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (advance)
        begin
            v_reg <= {v_reg[4:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sv_reg      <= sv_next;
            drift_reg   <= in_data.step_drift;
            side_reg[1] <= '{in_data.path_start, in_data.dividend_kind,
                             in_data.dividend_amount};
            ym_reg      <= ym_next;
            side_reg[2] <= side_reg[1];
            rp_reg      <= rp_next;
            idx3_reg    <= f[31 -: IDXW];
            e3_reg      <= y[43:32];
            side_reg[3] <= side_reg[2];
            t_reg       <= t_next;
            tt_reg      <= tt_next;
            idx4_reg    <= idx3_reg;
            e4_reg      <= e3_reg;
            side_reg[4] <= side_reg[3];
            mant_reg    <= mant_next;
            e5_reg      <= e4_reg;
            side_reg[5] <= side_reg[4];
        end
    end

    assign push_data = '{e5_reg, mant_reg, side_reg[5]};

    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[5] && q_full) |=> (v_reg[5] && $stable(mant_reg)))
        else $error("front last stage lost while queue full");
    a_push_gate: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("push into full queue");
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> v_reg[5])
        else $error("input stalled with empty last stage");

endmodule

### rtl/gpps_queue.sv
module gpps_queue
    import gpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  gpps_item_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       q_valid,
    output gpps_item_t q_data
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    gpps_item_t           mem [QUEUE_DEPTH];
    logic [PW-1:0]        wp_reg, rp_reg;
    logic [PW:0]          count_reg;

    assign full    = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wp_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

### rtl/gpps_back.sv
module gpps_back
    import gpps_pkg::*;
#(
    parameter int PRICE_WIDTH = DEF_PRICE_WIDTH
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [PRICE_FIELD_W-1:0] start_price,
    input  logic                     q_valid,
    input  gpps_item_t               q_data,
    output logic                     pop,
    output logic                     out_valid,
    input  logic                     out_stall,
    output gpps_out_t                out_data
);

    localparam int H   = PRICE_WIDTH / 2;
    localparam int PRW = PRICE_WIDTH + MANT_W;
    localparam int RW  = PRW + PRICE_WIDTH;
    localparam logic [PRICE_WIDTH-1:0] PMAX = '1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL0  = 3'd1;
    localparam logic [2:0] ST_MUL1  = 3'd2;
    localparam logic [2:0] ST_SHIFT = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    logic [2:0]               state_reg;
    logic [PRICE_WIDTH-1:0]   running_reg;
    logic [PRICE_WIDTH-1:0]   p_reg;
    logic [MANT_W-1:0]        mant_reg;
    logic signed [EXP_W-1:0]  e_reg;
    logic [1:0]               kind_reg;
    logic [PRICE_FIELD_W-1:0] amt_reg;
    logic [PRW-1:0]           prod_reg;
    logic [PRICE_WIDTH-1:0]   g_reg;
    logic                     sat_reg;
    logic                     out_valid_reg;
    gpps_out_t                out_data_reg;

    logic [PRICE_WIDTH-1:0]   start_clamped;
    logic [PRW-1:0]           pp_lo;
    logic [PRW-1:0]           pp_hi;
    logic signed [EXP_W:0]    sh;
    logic [EXP_W:0]           lsh;
    logic [RW-1:0]            wide;
    logic                     sat_next;
    logic [PRICE_WIDTH-1:0]   g_next;
    logic [PRICE_WIDTH+16:0]  dprod;
    logic [PRICE_WIDTH-1:0]   final_p;
    logic                     flo;
    logic                     out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign pop       = (state_reg == ST_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        start_clamped = (65'(start_price) > 65'(PMAX)) ? PMAX
                                                       : PRICE_WIDTH'(start_price);
        pp_lo = PRW'(p_reg[H-1:0]) * PRW'(mant_reg);
        pp_hi = (PRW'(p_reg[PRICE_WIDTH-1:H]) * PRW'(mant_reg)) << H;

        sh       = (EXP_W+1)'(32) - (EXP_W+1)'(e_reg);
        lsh      = (EXP_W+1)'(-sh);
        wide     = '0;
        sat_next = 1'b0;
        if (!sh[EXP_W])
        begin
            wide = RW'(prod_reg) >> sh;
        end
        else if (lsh > (EXP_W+1)'(PRICE_WIDTH))
        begin
            sat_next = (prod_reg != '0);
        end
        else
        begin
            wide = RW'(prod_reg) << lsh;
        end
        if (wide[RW-1:PRICE_WIDTH] != '0)
            sat_next = 1'b1;
        g_next = sat_next ? PMAX : wide[PRICE_WIDTH-1:0];

        dprod   = (PRICE_WIDTH+17)'(g_reg)
                * (PRICE_WIDTH+17)'(17'd65536 - 17'(amt_reg[15:0]));
        flo     = 1'b0;
        final_p = g_reg;
        unique case (kind_reg)
            DIV_CASH:
            begin
                if (65'(amt_reg) > 65'(g_reg))
                begin
                    final_p = '0;
                    flo     = 1'b1;
                end
                else
                begin
                    final_p = g_reg - PRICE_WIDTH'(amt_reg);
                end
            end
            DIV_PROP: final_p = dprod[16 +: PRICE_WIDTH];
            default:  final_p = g_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            running_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DIV && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                        state_reg <= ST_MUL0;
                end
                ST_MUL0:  state_reg <= ST_MUL1;
                ST_MUL1:  state_reg <= ST_SHIFT;
                ST_SHIFT: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (out_free)
                    begin
                        running_reg   <= final_p;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            p_reg    <= q_data.side.path_start ? start_clamped : running_reg;
            mant_reg <= q_data.mant;
            e_reg    <= q_data.e;
            kind_reg <= q_data.side.dividend_kind;
            amt_reg  <= q_data.side.dividend_amount;
        end
        if (state_reg == ST_MUL0)
            prod_reg <= pp_lo;
        if (state_reg == ST_MUL1)
            prod_reg <= prod_reg + pp_hi;
        if (state_reg == ST_SHIFT)
        begin
            g_reg   <= g_next;
            sat_reg <= sat_next;
        end
        if (state_reg == ST_DIV && out_free)
            out_data_reg <= '{PRICE_FIELD_W'(final_p), sat_reg, flo};
    end

    a_floor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.floored && out_data_reg.price != '0))
        else $error("floored result with nonzero price");
    a_start_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && q_valid) |=> (state_reg == ST_MUL0))
        else $error("queued item not taken");
    a_running_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |=> $stable(running_reg))
        else $error("running price changed outside dividend step");

endmodule

### tb/sv/tb_gbm_price_path_step_unit.sv
module tb_gbm_price_path_step_unit;
    import gpps_pkg::*;

    localparam logic [47:0]        PRICE_TOP  = 48'hFFFF_FFFF_FFFF;
    localparam longint             LOG2E_K    = 64'sd1549082005;
    localparam logic [63:0]        LN2_K      = 64'd2977044472;
    localparam logic [63:0]        UNIT_Q32   = 64'h1_0000_0000;
    localparam int                 TAB_DEPTH  = 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    gpps_in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    gpps_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [PRICE_FIELD_W-1:0] cfg_data = '0;

    gbm_price_path_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    gpps_in_t   step_q[$];
    gpps_out_t  node_exp_q[$];
    logic [63:0] pow2_tab[TAB_DEPTH];
    logic [47:0] start_reg = START_PRICE_RESET;
    logic [47:0] path_price = '0;
    bit          calm = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          sent_cnt = 0;
    int          got_cnt = 0;
    int          err_cnt = 0;
    int          sat_cnt = 0;
    int          flo_cnt = 0;

    function automatic void build_pow2_tab();
        logic [63:0]  a;
        logic [63:0]  term;
        logic [63:0]  sum;
        logic [127:0] prod;
        for (int j = 0; j < TAB_DEPTH; j++)
        begin
            a = (64'(j) * LN2_K) / TAB_DEPTH;
            term = UNIT_Q32;
            sum = UNIT_Q32;
            for (int k = 1; k < 40; k++)
            begin
                prod = 128'(term) * 128'(a);
                term = 64'(prod >> 32) / 64'(k);
                if (term == 0)
                    break;
                sum = sum + term;
            end
            pow2_tab[j] = sum;
        end
    endfunction

    function automatic logic [47:0] shift_clamp(logic [127:0] v, longint sh, output logic sat);
        sat = 1'b0;
        if (v == 0 || sh >= 128)
            return '0;
        if (sh >= 0)
            v = v >> sh;
        else
        begin
            if (-sh >= 64 || (v >> (64 + sh)) != 0)
            begin
                sat = 1'b1;
                return PRICE_TOP;
            end
            v = v << (-sh);
        end
        if (v > 128'(PRICE_TOP))
        begin
            sat = 1'b1;
            return PRICE_TOP;
        end
        return v[47:0];
    endfunction

    function automatic gpps_out_t advance_price(gpps_in_t it);
        longint       x;
        longint       y;
        longint       e;
        logic [63:0]  f;
        logic [63:0]  idx;
        logic [63:0]  rem;
        logic [63:0]  t;
        logic [63:0]  corr;
        logic [63:0]  mant;
        logic [127:0] prod;
        logic [47:0]  p;
        logic         sat;
        logic         dummy;
        gpps_out_t    r;
        if (it.path_start)
            path_price = start_reg;
        x = ((longint'(it.normal_sample) * longint'(it.step_vol) + 2048) >>> 12)
            + longint'(it.step_drift);
        y = (x * LOG2E_K) >>> 14;
        e = y >>> 32;
        f = y & 64'hFFFF_FFFF;
        idx = f >> 24;
        rem = (f << 8) & 64'hFFFF_FFFF;
        t = ((rem * LN2_K) >> 32) / TAB_DEPTH;
        corr = UNIT_Q32 + t + ((t * t) >> 33);
        prod = 128'(pow2_tab[idx]) * 128'(corr >> 2);
        mant = 64'(prod >> 30);
        prod = 128'(path_price) * 128'(mant);
        p = shift_clamp(prod, 32 - e, sat);
        r = '0;
        r.saturated = sat;
        if (it.dividend_kind == DIV_CASH)
        begin
            if (it.dividend_amount > p)
            begin
                p = '0;
                r.floored = 1'b1;
            end
            else
                p = p - it.dividend_amount;
        end
        else if (it.dividend_kind == DIV_PROP)
        begin
            prod = 128'(p) * 128'(65536 - it.dividend_amount[15:0]);
            p = shift_clamp(prod, 16, dummy);
        end
        path_price = p;
        r.price = p;
        return r;
    endfunction

    function automatic void add_step(gpps_in_t s);
        step_q = {step_q, s};
    endfunction

    function automatic gpps_in_t mk_step(bit ps, int smp, int drift, int vol,
                                         logic [1:0] kind, logic [47:0] amt);
        gpps_in_t s;
        s.normal_sample = 16'(smp);
        s.step_drift = 20'(drift);
        s.step_vol = 20'(vol);
        s.path_start = ps;
        s.dividend_kind = kind;
        s.dividend_amount = amt;
        return s;
    endfunction

    function automatic gpps_in_t rand_step(bit ps);
        gpps_in_t s;
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            s = $bits(gpps_in_t)'({$urandom, $urandom, $urandom, $urandom});
            return s;
        end
        s.path_start = ps;
        s.normal_sample = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                          : 16'($urandom_range(0, 24576)) - 16'd12288;
        s.step_drift = 20'($urandom_range(0, 2000)) - 20'd1000;
        s.step_vol = ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, 13107));
        r = $urandom_range(0, 99);
        if (r < 75)
        begin
            s.dividend_kind = DIV_NONE;
            s.dividend_amount = 48'($urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 0);
        end
        else if (r < 88)
        begin
            s.dividend_kind = DIV_CASH;
            s.dividend_amount = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom})
                                : 48'($urandom_range(0, 65536 * 8));
        end
        else if (r < 97)
        begin
            s.dividend_kind = DIV_PROP;
            s.dividend_amount = 48'({$urandom, $urandom});
        end
        else
        begin
            s.dividend_kind = 2'd3;
            s.dividend_amount = 48'({$urandom, $urandom});
        end
        return s;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && !(in_valid && in_stall))
        begin
            if (in_valid)
            begin
                node_exp_q = {node_exp_q, advance_price(in_data)};
                sent_cnt++;
            end
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (step_q.size() > 0)
            begin
                in_data <= step_q.pop_front();
                in_valid <= 1'b1;
                gap_left <= draw_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && got_cnt == 200)
        begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        gpps_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got_cnt++;
                if (node_exp_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected price node %h", out_data);
                end
                else
                begin
                    want = node_exp_q.pop_front();
                    sat_cnt += want.saturated;
                    flo_cnt += want.floored;
                    if (out_data.price !== want.price || out_data.saturated !== want.saturated
                        || out_data.floored !== want.floored)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("node %0d: exp price %h sat %b flo %b, got %h %b %b",
                                     got_cnt, want.price, want.saturated, want.floored,
                                     out_data.price, out_data.saturated, out_data.floored);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_left > 0)
                out_stall <= 1'b1;
            else if (calm)
                out_stall <= 1'b0;
            else
            begin
                if ($urandom_range(0, 99) < 3)
                    stall_left <= $urandom_range(15, 50);
                out_stall <= ($urandom_range(0, 99) < 30);
            end
        end
    end

    task automatic drain();
        while (step_q.size() > 0 || in_valid || node_exp_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_start(logic [47:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        start_reg = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_paths(int n);
        int left;
        left = 0;
        for (int i = 0; i < n; i++)
        begin
            if (left == 0)
                left = $urandom_range(1, 20);
            add_step(rand_step(left == 1 || i == 0 ? 1'b1 : 1'b0));
            left--;
        end
    endtask

    initial
    begin
        logic [47:0] starts[6];
        starts = '{48'd0, PRICE_TOP, 48'd1, 48'd6553600, 48'h0000_0100_0000, 48'h7FFF_0000_0000};
        build_pow2_tab();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_step(mk_step(1, 0, 0, 0, DIV_NONE, 0));
        add_step(mk_step(0, 0, 0, 0, DIV_CASH, START_PRICE_RESET));
        add_step(mk_step(1, 0, 0, 0, DIV_CASH, START_PRICE_RESET + 1));
        add_step(mk_step(1, -32768, -524288, 1048575, DIV_NONE, 0));
        add_step(mk_step(0, 32767, 524287, 1048575, DIV_NONE, 0));
        add_step(mk_step(1, 32767, 524287, 1048575, DIV_NONE, 0));
        add_step(mk_step(0, 32767, 524287, 1048575, DIV_PROP, PRICE_TOP));
        add_step(mk_step(1, -32768, 0, 1048575, DIV_NONE, 0));
        add_step(mk_step(1, 32767, -524288, 0, DIV_PROP, 48'hFFFF_FFFF_0000));
        add_step(mk_step(1, 4096, 1000, 65536, DIV_PROP, 48'hFFFF));
        add_step(mk_step(0, -4096, -1000, 65536, DIV_PROP, 48'h8000));
        add_step(mk_step(1, 1234, 3000, 20000, 2'd3, PRICE_TOP));
        add_step(mk_step(0, 0, 0, 0, DIV_CASH, PRICE_TOP));
        add_step(mk_step(0, 5000, 8000, 30000, DIV_NONE, 0));
        add_step(mk_step(1, -1, 1, 1, DIV_CASH, 48'd65536));
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_start(starts[ph]);
            if (ph == 1)
            begin
                add_step(mk_step(1, 32767, 524287, 1048575, DIV_NONE, 0));
                add_step(mk_step(1, 0, 0, 0, DIV_CASH, PRICE_TOP));
            end
            calm = (ph % 3 == 2);
            random_paths(230);
            drain();
        end
        calm = 1'b0;

        $display("%0d steps sent over six start prices, %0d nodes checked",
                 sent_cnt, got_cnt);
        $display("%0d clamped and %0d floored nodes seen", sat_cnt, flo_cnt);
        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
